// ===== rtl/eft_pkg.sv =====
// eft_pkg: shared types, codes and helpers of the eta file transform unit.
// No dependencies; used by eft_div, eta_file_transform_unit and eft_checker.
package eft_pkg;

    localparam int DATA_W = 32;

    // item function codes
    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_FWD    = 2'd2;
    localparam logic [1:0] FUNC_BWD    = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    // configuration register indexes
    localparam logic CFG_DIM = 1'b0;
    localparam logic CFG_TOL = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_SWEEP, S_NEXT, S_PIV, S_DP, S_DIV,
        S_ERD, S_EMUL, S_EPRD, S_EWB, S_ORD, S_OLD
    } t_state;

    typedef struct packed {
        logic                     start;
        logic signed [DATA_W-1:0] num;
        logic signed [DATA_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                     done;
        logic                     sat;
        logic signed [DATA_W-1:0] quo;
    } t_div_rsp;

    // {overflow flag, value clamped to 32 bits}
    function automatic logic [DATA_W:0] sat32(input logic signed [63:0] x);
        logic [DATA_W:0] r;
        if (x > 64'sd2147483647) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (x < -64'sd2147483648) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, x[DATA_W-1:0]};
        end
        return r;
    endfunction

endpackage

// ===== rtl/eft_ram.sv =====
// eft_ram: generic single-port-write, single-port-read RAM, registered read.
// No dependencies.
module eft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/eft_div.sv =====
// eft_div: restoring divider, (num << FRAC_BITS) / den, truncated, saturated.
// Depends on eft_pkg. One quotient bit per cycle.
module eft_div
    import eft_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    localparam int DW = DATA_W + FRAC_BITS;
    localparam int CW = $clog2(DW);

    logic              r_busy, r_done, r_neg;
    logic [CW-1:0]     r_cnt;
    logic [DATA_W-1:0] r_rem, r_dvs;
    logic [DW-1:0]     r_quo;

    logic [DATA_W-1:0] num_mag, den_mag;
    logic [DATA_W:0]   rem_sh, rem_dif;
    logic              ge;
    logic signed [63:0] q64, qv;
    logic [DATA_W:0]   qs;

    assign num_mag = i_req.num[DATA_W-1] ? 32'd0 - i_req.num : i_req.num;
    assign den_mag = i_req.den[DATA_W-1] ? 32'd0 - i_req.den : i_req.den;
    assign rem_sh  = {r_rem, r_quo[DW-1]};
    assign rem_dif = rem_sh - {1'b0, r_dvs};
    assign ge      = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(DW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= {num_mag, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_dvs <= den_mag;
            r_neg <= i_req.num[DATA_W-1] ^ i_req.den[DATA_W-1];
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? rem_dif[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            r_quo <= {r_quo[DW-2:0], ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign q64 = 64'(r_quo);
    assign qv  = r_neg ? -q64 : q64;
    assign qs  = sat32(qv);

    assign o_rsp.done = r_done;
    assign o_rsp.sat  = qs[DATA_W];
    assign o_rsp.quo  = qs[DATA_W-1:0];
endmodule

// ===== rtl/eta_file_transform_unit.sv =====
// eta_file_transform_unit: product-form eta file with forward/backward passes.
// Depends on eft_pkg, eft_ram (eta store, pivots, work vector) and eft_div.
//
//  channel | direction | handshake                  | payload
//  in      | to block  | i_in_valid / o_in_ready    | func, piv_row, elem_index, elem_value, is_last
//  out     | from block| o_out_valid / i_out_ready  | out_index, out_value, out_last, status, eta_count
//  cfg     | to block  | i_cfg_valid / o_cfg_ready  | cfg_index (0 dim, 1 tol), cfg_data
//
// Elements without a result are taken while the block stays idle. A committed column
// adds a sweep over all MAX_DIM entries of its store row. A pass skips an eta with a
// stale pivot or a pivot entry not above the tolerance; for each usable eta it passes
// every other element through the one multiplier and makes one divide, all on the
// one work vector RAM; then it gives each result in turn.
// Synchronous active-low reset; the RAMs hold no reset, written-bit masks cover them.
// A stalled output holds the block; no request is taken while the output register is full and not being read.
// Configuration requests are taken only while the block is idle.
module eta_file_transform_unit
    import eft_pkg::*;
#(
    parameter int MAX_DIM   = 64,
    parameter int MAX_ETAS  = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_func,
    input  logic [5:0]         i_piv_row,
    input  logic [5:0]         i_elem_index,
    input  logic signed [31:0] i_elem_value,
    input  logic               i_is_last,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [5:0]         o_out_index,
    output logic signed [31:0] o_out_value,
    output logic               o_out_last,
    output logic [1:0]         o_status,
    output logic [5:0]         o_eta_count,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    localparam int IW  = $clog2(MAX_DIM);
    localparam int SW  = (MAX_ETAS > 1) ? $clog2(MAX_ETAS) : 1;
    localparam int UW  = $clog2(MAX_ETAS + 1);
    localparam int EAW = SW + IW;
    localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

    t_state r_state, n_state;

    logic [6:0]  r_dim;
    logic [30:0] r_tol;

    logic [UW-1:0] r_used, n_used, r_k, n_k;
    logic          r_open, n_open;
    logic [1:0]    r_kind, n_kind, r_flags, n_flags;
    logic [5:0]    r_open_piv, n_open_piv;
    logic [31:0]   r_pval, n_pval;
    logic [MAX_DIM-1:0] r_cmask, n_cmask, r_vmask, n_vmask;
    logic [SW-1:0] r_slot, n_slot;
    logic [6:0]    r_i, n_i;
    logic [IW-1:0] r_p, n_p;
    logic signed [31:0] r_dp, n_dp, r_vp, n_vp, r_vi, n_vi, r_xp, n_xp, r_ma, n_ma;
    logic signed [63:0] r_prod, n_prod, r_acc, n_acc;
    logic          r_sat, n_sat, r_fwd, n_fwd;

    logic          r_ovalid, n_ovalid;
    logic [5:0]    r_oidx, n_oidx;
    logic [31:0]   r_oval, n_oval;
    logic          r_olast, n_olast;
    logic [1:0]    r_ostat, n_ostat;
    logic [5:0]    r_ocnt, n_ocnt;

    // RAM ports
    logic           e_we, e_re, p_we, p_re, v_we, v_re;
    logic [EAW-1:0] e_waddr, e_raddr;
    logic [31:0]    e_wdata, e_rdata, v_wdata, v_rdata;
    logic [SW-1:0]  p_waddr, p_raddr;
    logic [IW-1:0]  p_wdata, p_rdata, v_waddr, v_raddr;

    t_div_req div_req;
    t_div_rsp div_rsp;

    // shared conditions
    logic [6:0]  dim_n;
    logic        in_acc, out_free, new_run, idx_ok, k_done, piv_ok, dp_live;
    logic        elem_end, elem_skip, sweep_end, out_end;
    logic [1:0]  eff_flags;
    logic [5:0]  eff_piv;
    logic [31:0] dp_mag;
    logic signed [63:0] f_prod, vi64, vp64;
    logic [32:0] wb_sat, num_sat;

    assign dim_n = (r_dim == 7'd0) ? 7'd1 :
                   (r_dim > 7'(MAX_DIM)) ? 7'(MAX_DIM) : r_dim;
    assign out_free   = !r_ovalid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign in_acc  = i_in_valid && o_in_ready;
    assign new_run = !r_open || (r_kind != i_func);
    assign idx_ok  = {1'b0, i_elem_index} < dim_n;
    assign eff_piv = new_run ? i_piv_row : r_open_piv;
    assign eff_flags = !new_run ? r_flags :
                       (r_used >= UW'(MAX_ETAS)) ? ST_FULL :
                       ({1'b0, i_piv_row} >= dim_n) ? ST_RANGE : ST_OK;
    assign k_done   = r_fwd ? (r_k == r_used) : (r_k == '0);
    assign piv_ok   = 7'(p_rdata) < dim_n;
    assign dp_mag   = e_rdata[31] ? 32'd0 - e_rdata : e_rdata;
    assign dp_live  = dp_mag > {1'b0, r_tol};
    assign elem_end  = r_i == dim_n;
    assign elem_skip = r_i == 7'(r_p);
    assign sweep_end = r_i == 7'(MAX_DIM - 1);
    assign out_end   = r_i == dim_n - 7'd1;
    assign f_prod  = r_prod >>> FRAC_BITS;
    assign vi64    = r_vi;
    assign vp64    = r_vp;
    assign wb_sat  = sat32(vi64 - f_prod);
    assign num_sat = sat32(vp64 - r_acc);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_func != FUNC_CLEAR && i_is_last) begin
                    if (i_func == FUNC_APPEND) begin
                        if (eff_flags == ST_OK) n_state = S_SWEEP;
                    end else begin
                        n_state = S_NEXT;
                    end
                end
            end
            S_SWEEP: if (sweep_end) n_state = S_IDLE;
            S_NEXT:  n_state = k_done ? S_ORD : S_PIV;
            S_PIV:   n_state = piv_ok ? S_DP : S_NEXT;
            S_DP: begin
                if (!dp_live) n_state = S_NEXT;
                else n_state = r_fwd ? S_DIV : S_ERD;
            end
            S_DIV:   if (div_rsp.done) n_state = r_fwd ? S_ERD : S_NEXT;
            S_ERD: begin
                if (elem_end) n_state = r_fwd ? S_NEXT : S_DIV;
                else if (!elem_skip) n_state = S_EMUL;
            end
            S_EMUL:  n_state = S_EPRD;
            S_EPRD:  n_state = S_EWB;
            S_EWB:   n_state = S_ERD;
            S_ORD:   n_state = S_OLD;
            S_OLD:   if (out_free) n_state = out_end ? S_IDLE : S_ORD;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath, memory control and outputs
    always_comb begin
        n_used = r_used;  n_k = r_k;  n_open = r_open;  n_kind = r_kind;
        n_flags = r_flags;  n_open_piv = r_open_piv;  n_pval = r_pval;
        n_cmask = r_cmask;  n_vmask = r_vmask;  n_slot = r_slot;  n_i = r_i;
        n_p = r_p;  n_dp = r_dp;  n_vp = r_vp;  n_vi = r_vi;  n_xp = r_xp;
        n_ma = r_ma;  n_prod = r_prod;  n_acc = r_acc;  n_sat = r_sat;  n_fwd = r_fwd;
        n_ovalid = r_ovalid && !i_out_ready;
        n_oidx = r_oidx;  n_oval = r_oval;  n_olast = r_olast;
        n_ostat = r_ostat;  n_ocnt = r_ocnt;
        e_we = 1'b0;  e_waddr = {r_slot, r_i[IW-1:0]};  e_wdata = '0;
        e_re = 1'b0;  e_raddr = {r_slot, r_i[IW-1:0]};
        p_we = 1'b0;  p_waddr = SW'(r_used);  p_wdata = eff_piv[IW-1:0];
        p_re = 1'b0;  p_raddr = r_slot;
        v_we = 1'b0;  v_waddr = r_i[IW-1:0];  v_wdata = '0;
        v_re = 1'b0;  v_raddr = r_i[IW-1:0];
        div_req = '{start: 1'b0, num: r_vp, den: r_dp};

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_func == FUNC_CLEAR) begin
                        n_used = '0;  n_open = 1'b0;  n_flags = ST_OK;  n_kind = FUNC_CLEAR;
                        n_ovalid = 1'b1;  n_oidx = '0;  n_oval = '0;  n_olast = 1'b1;
                        n_ostat = ST_OK;  n_ocnt = '0;
                    end else if (i_func == FUNC_APPEND) begin
                        n_open = 1'b1;  n_kind = i_func;  n_flags = eff_flags;
                        n_open_piv = eff_piv;
                        n_cmask = new_run ? '0 : r_cmask;
                        n_pval  = new_run ? '0 : r_pval;
                        if (eff_flags == ST_OK && idx_ok) begin
                            e_we = 1'b1;
                            e_waddr = {SW'(r_used), i_elem_index[IW-1:0]};
                            e_wdata = i_elem_value;
                            n_cmask[i_elem_index[IW-1:0]] = 1'b1;
                            if (i_elem_index == eff_piv) n_pval = i_elem_value;
                        end
                        if (i_is_last) begin
                            n_open = 1'b0;  n_kind = FUNC_CLEAR;  n_flags = ST_OK;
                            n_ovalid = 1'b1;  n_oidx = eff_piv;  n_oval = '0;
                            n_olast = 1'b1;  n_ostat = eff_flags;  n_ocnt = 6'(r_used);
                            if (eff_flags == ST_OK) begin
                                p_we = 1'b1;
                                n_slot = SW'(r_used);
                                n_used = r_used + 1'b1;
                                n_ocnt = 6'(r_used + 1'b1);
                                n_i = '0;
                            end
                        end
                    end else begin
                        n_open = 1'b1;  n_kind = i_func;
                        n_vmask = new_run ? '0 : r_vmask;
                        if (idx_ok) begin
                            v_we = 1'b1;
                            v_waddr = i_elem_index[IW-1:0];
                            v_wdata = i_elem_value;
                            n_vmask[i_elem_index[IW-1:0]] = 1'b1;
                        end
                        if (i_is_last) begin
                            n_open = 1'b0;  n_kind = FUNC_CLEAR;
                            n_fwd = i_func == FUNC_FWD;
                            n_sat = 1'b0;
                            n_k = (i_func == FUNC_FWD) ? '0 : r_used;
                        end
                    end
                end
            end
            S_SWEEP: begin
                // zero the rest of the new column; a zero pivot entry becomes 1.0
                if (r_i == 7'(r_open_piv)) begin
                    e_we = 1'b1;
                    e_wdata = (r_pval == '0) ? ONE : r_pval;
                end else if (!r_cmask[r_i[IW-1:0]]) begin
                    e_we = 1'b1;
                end
                n_i = r_i + 7'd1;
            end
            S_NEXT: begin
                if (!k_done) begin
                    p_re = 1'b1;
                    if (r_fwd) begin
                        p_raddr = SW'(r_k);
                        n_slot = SW'(r_k);
                        n_k = r_k + 1'b1;
                    end else begin
                        p_raddr = SW'(r_k - 1'b1);
                        n_slot = SW'(r_k - 1'b1);
                        n_k = r_k - 1'b1;
                    end
                end
                n_i = '0;
            end
            S_PIV: begin
                n_p = p_rdata;
                e_re = 1'b1;  e_raddr = {r_slot, p_rdata};
                v_re = 1'b1;  v_raddr = p_rdata;
            end
            S_DP: begin
                n_dp = e_rdata;
                n_vp = r_vmask[r_p] ? v_rdata : '0;
                n_acc = '0;
                n_i = '0;
                if (dp_live && r_fwd) begin
                    div_req = '{start: 1'b1, num: (r_vmask[r_p] ? v_rdata : '0), den: e_rdata};
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    v_we = 1'b1;  v_waddr = r_p;  v_wdata = div_rsp.quo;
                    n_vmask[r_p] = 1'b1;
                    n_xp = div_rsp.quo;
                    n_sat = r_sat | div_rsp.sat;
                    n_i = '0;
                end
            end
            S_ERD: begin
                if (elem_end) begin
                    if (!r_fwd) begin
                        n_sat = r_sat | num_sat[32];
                        div_req = '{start: 1'b1, num: num_sat[31:0], den: r_dp};
                    end
                end else if (elem_skip) begin
                    n_i = r_i + 7'd1;
                end else begin
                    e_re = 1'b1;
                    v_re = 1'b1;
                end
            end
            S_EMUL: begin
                n_ma = e_rdata;
                n_vi = r_vmask[r_i[IW-1:0]] ? v_rdata : '0;
            end
            S_EPRD: begin
                n_prod = r_ma * (r_fwd ? r_xp : r_vi);
            end
            S_EWB: begin
                if (r_fwd) begin
                    v_we = 1'b1;
                    v_wdata = wb_sat[31:0];
                    n_vmask[r_i[IW-1:0]] = 1'b1;
                    n_sat = r_sat | wb_sat[32];
                end else begin
                    n_acc = r_acc + f_prod;
                end
                n_i = r_i + 7'd1;
            end
            S_ORD: begin
                v_re = 1'b1;
            end
            S_OLD: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oidx = 6'(r_i);
                    n_oval = r_vmask[r_i[IW-1:0]] ? v_rdata : '0;
                    n_olast = out_end;
                    n_ostat = r_sat ? ST_SAT : ST_OK;
                    n_ocnt = 6'(r_used);
                    n_i = r_i + 7'd1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used <= '0;
            r_open <= 1'b0;
            r_kind <= FUNC_CLEAR;
            r_flags <= ST_OK;
            r_cmask <= '0;
            r_vmask <= '0;
            r_ovalid <= 1'b0;
            r_sat <= 1'b0;
            r_fwd <= 1'b0;
            r_k <= '0;
            r_i <= '0;
        end else begin
            r_state <= n_state;
            r_used <= n_used;
            r_open <= n_open;
            r_kind <= n_kind;
            r_flags <= n_flags;
            r_cmask <= n_cmask;
            r_vmask <= n_vmask;
            r_ovalid <= n_ovalid;
            r_sat <= n_sat;
            r_fwd <= n_fwd;
            r_k <= n_k;
            r_i <= n_i;
        end
    end

    always_ff @(posedge i_clk) begin
        r_open_piv <= n_open_piv;  r_pval <= n_pval;  r_slot <= n_slot;
        r_p <= n_p;  r_dp <= n_dp;  r_vp <= n_vp;  r_vi <= n_vi;  r_xp <= n_xp;
        r_ma <= n_ma;  r_prod <= n_prod;  r_acc <= n_acc;
        r_oidx <= n_oidx;  r_oval <= n_oval;  r_olast <= n_olast;
        r_ostat <= n_ostat;  r_ocnt <= n_ocnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= 7'd64;
            r_tol <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DIM: r_dim <= i_cfg_data[6:0];
                CFG_TOL: r_tol <= i_cfg_data[30:0];
                default: r_tol <= r_tol;
            endcase
        end
    end

    eft_ram #(.WIDTH(32), .DEPTH(2 ** EAW)) u_eta_ram (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_waddr), .i_wdata(e_wdata),
        .i_re(e_re), .i_raddr(e_raddr), .o_rdata(e_rdata)
    );

    eft_ram #(.WIDTH(IW), .DEPTH(2 ** SW)) u_piv_ram (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_re(p_re), .i_raddr(p_raddr), .o_rdata(p_rdata)
    );

    eft_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_vec_ram (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_re(v_re), .i_raddr(v_raddr), .o_rdata(v_rdata)
    );

    eft_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp)
    );

    assign o_out_valid = r_ovalid;
    assign o_out_index = r_oidx;
    assign o_out_value = r_oval;
    assign o_out_last  = r_olast;
    assign o_status    = r_ostat;
    assign o_eta_count = r_ocnt;
endmodule

// ===== rtl/eft_checker.sv =====
// eft_checker: port-level checks of eta_file_transform_unit, bound to the top.
// Depends on eft_pkg and eta_file_transform_unit.
module eft_checker
    import eft_pkg::*;
#(
    parameter int MAX_ETAS = 32
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic [1:0]         i_func,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [5:0]         o_out_index,
    input logic signed [31:0] o_out_value,
    input logic               o_out_last,
    input logic [1:0]         o_status,
    input logic [5:0]         o_eta_count
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_value)
            && $stable(o_out_index) && $stable(o_out_last))
        else $error("stalled result changed");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_func == FUNC_CLEAR
            |=> o_out_valid && o_out_last && o_eta_count == 6'd0 && o_status == ST_OK)
        else $error("clear request gave no empty-file result");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid || i_out_ready)
        else $error("request taken while result register full");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> MAX_ETAS >= 64 || o_eta_count <= 6'(MAX_ETAS))
        else $error("eta count beyond capacity");

    a_flag_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL || o_status == ST_RANGE)
            |-> o_out_last && o_out_value == 32'sd0)
        else $error("rejected column result malformed");
endmodule

bind eta_file_transform_unit eft_checker #(.MAX_ETAS(MAX_ETAS)) u_eft_checker (.*);
